FILE: rtl/hsvc_pkg.sv
// shared types and constants for the hsv to rgb color pipeline
// no dependencies; used by every module of the block

package hsvc_pkg;

	// hue split: quotient by 60 through a reciprocal multiply
	localparam logic [10:0] HUE_RECIP   = 11'd1093;
	localparam int          HUE_SHIFT   = 16;
	localparam logic [8:0]  SECTOR_SPAN = 9'd60;
	localparam logic [3:0]  SECTORS     = 4'd6;

	// p = round(v * (255 - s) / 255)
	localparam logic [7:0]  FULL_SCALE  = 8'd255;
	localparam logic [16:0] P_BIAS      = 17'd127;
	localparam logic [17:0] P_RECIP     = 18'd131587;
	localparam int          P_SHIFT     = 25;

	// q, t = round(v * (15300 - x) / 15300)
	localparam logic [13:0] QT_DEN      = 14'd15300;
	localparam logic [13:0] QT_BIAS     = 14'd7650;
	localparam logic [21:0] QT_RECIP    = 22'd2245735;
	localparam int          QT_SHIFT    = 33;

	// hue sectors
	localparam logic [2:0]  SECT_RED    = 3'd0;
	localparam logic [2:0]  SECT_YEL    = 3'd1;
	localparam logic [2:0]  SECT_GRN    = 3'd2;
	localparam logic [2:0]  SECT_CYN    = 3'd3;
	localparam logic [2:0]  SECT_BLU    = 3'd4;
	localparam logic [2:0]  SECT_MAG    = 3'd5;

	typedef struct packed {
		logic [7:0]  alpha;
		logic [2:0]  sector;
		logic [5:0]  rem;
		logic [7:0]  sat;
		logic [7:0]  val;
		logic [15:0] np;
	} front_t;

	typedef struct packed {
		logic [7:0]  alpha;
		logic [2:0]  sector;
		logic [7:0]  val;
		logic [7:0]  p;
		logic [21:0] nq;
		logic [21:0] nt;
	} mid_t;

endpackage

FILE: rtl/hsvc_if.sv
// valid/ready channel interfaces for pixel beats in and out
// no dependencies

interface hsvc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] color_in;
	logic [8:0]  hue;
	logic [7:0]  saturation;
	logic [7:0]  brightness;

	modport source (output valid, color_in, hue, saturation, brightness, input ready);
	modport sink (input valid, color_in, hue, saturation, brightness, output ready);
endinterface

interface hsvc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] color_out;

	modport source (output valid, color_out, input ready);
	modport sink (input valid, color_out, output ready);
endinterface

FILE: rtl/hsvc_front.sv
// stages 1 and 2: hue split into sector and remainder, v * (255 - s) product
// depends on hsvc_pkg and hsvc_in_if

module hsvc_front (
	input  logic             clk,
	input  logic             arst_n,
	hsvc_in_if.sink          pix_in,
	output logic             dn_valid,
	input  logic             dn_ready,
	output hsvc_pkg::front_t dn_data
);

	localparam int HUE_SHIFT_HI = hsvc_pkg::HUE_SHIFT + 3;

	logic              vld_s1, vld_s2;
	logic              en1, en2;
	logic [19:0]       hue_prod;
	logic [3:0]        quot_s1;
	logic [8:0]        hue_s1;
	logic [7:0]        sat_s1, val_s1, alpha_s1;
	logic [8:0]        quot_x60;
	logic [8:0]        rem9;
	logic [3:0]        sect_wide;
	logic [15:0]       np;
	hsvc_pkg::front_t  data_s2;

	assign en2 = !vld_s2 || dn_ready;
	assign en1 = !vld_s1 || en2;
	assign pix_in.ready = en1;

	assign hue_prod = 20'(pix_in.hue) * 20'(hsvc_pkg::HUE_RECIP);

	assign quot_x60  = 9'(quot_s1) * hsvc_pkg::SECTOR_SPAN;
	assign rem9      = hue_s1 - quot_x60;
	assign sect_wide = (quot_s1 >= hsvc_pkg::SECTORS) ? quot_s1 - hsvc_pkg::SECTORS : quot_s1;
	assign np        = 16'(val_s1) * 16'(hsvc_pkg::FULL_SCALE - sat_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= pix_in.valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && pix_in.valid) begin
			quot_s1  <= hue_prod[HUE_SHIFT_HI:hsvc_pkg::HUE_SHIFT];
			hue_s1   <= pix_in.hue;
			sat_s1   <= pix_in.saturation;
			val_s1   <= pix_in.brightness;
			alpha_s1 <= pix_in.color_in[31:24];
		end
		if (en2 && vld_s1) begin
			data_s2.alpha  <= alpha_s1;
			data_s2.sector <= sect_wide[2:0];
			data_s2.rem    <= rem9[5:0];
			data_s2.sat    <= sat_s1;
			data_s2.val    <= val_s1;
			data_s2.np     <= np;
		end
	end

	assign dn_valid = vld_s2;
	assign dn_data  = data_s2;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (data_s2.rem < 6'(hsvc_pkg::SECTOR_SPAN)))
		else $error("hue remainder out of range");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (data_s2.sector <= hsvc_pkg::SECT_MAG))
		else $error("hue sector out of range");

endmodule

FILE: rtl/hsvc_mid.sv
// stages 3 and 4: saturation products, p rounding, q and t numerators
// depends on hsvc_pkg

module hsvc_mid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  hsvc_pkg::front_t up_data,
	output logic             dn_valid,
	input  logic             dn_ready,
	output hsvc_pkg::mid_t   dn_data
);

	localparam int P_SHIFT_HI = hsvc_pkg::P_SHIFT + 7;

	logic              vld_s3, vld_s4;
	logic              en3, en4;
	logic [16:0]       py;
	logic [34:0]       pprod;
	logic [5:0]        rem_c;
	logic [13:0]       sr, sr2;
	logic [7:0]        alpha_s3, val_s3;
	logic [2:0]        sector_s3;
	logic [13:0]       sr_s3, sr2_s3;
	logic [34:0]       pprod_s3;
	hsvc_pkg::mid_t    data_s4;

	assign en4 = !vld_s4 || dn_ready;
	assign en3 = !vld_s3 || en4;
	assign up_ready = en3;

	assign py    = 17'(up_data.np) + hsvc_pkg::P_BIAS;
	assign pprod = 35'(py) * 35'(hsvc_pkg::P_RECIP);
	assign rem_c = 6'(hsvc_pkg::SECTOR_SPAN) - up_data.rem;
	assign sr    = 14'(up_data.sat) * 14'(up_data.rem);
	assign sr2   = 14'(up_data.sat) * 14'(rem_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en3) begin
				vld_s3 <= up_valid;
			end
			if (en4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && up_valid) begin
			alpha_s3  <= up_data.alpha;
			sector_s3 <= up_data.sector;
			val_s3    <= up_data.val;
			sr_s3     <= sr;
			sr2_s3    <= sr2;
			pprod_s3  <= pprod;
		end
		if (en4 && vld_s3) begin
			data_s4.alpha  <= alpha_s3;
			data_s4.sector <= sector_s3;
			data_s4.val    <= val_s3;
			data_s4.p      <= pprod_s3[P_SHIFT_HI:hsvc_pkg::P_SHIFT];
			data_s4.nq     <= 22'(val_s3) * 22'(hsvc_pkg::QT_DEN - sr_s3);
			data_s4.nt     <= 22'(val_s3) * 22'(hsvc_pkg::QT_DEN - sr2_s3);
		end
	end

	assign dn_valid = vld_s4;
	assign dn_data  = data_s4;

	a_p_below_v: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (data_s4.p <= data_s4.val))
		else $error("p exceeds value");

endmodule

FILE: rtl/hsvc_back.sv
// stages 5 and 6: q and t rounding, sector select, output register
// depends on hsvc_pkg and hsvc_out_if

module hsvc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  hsvc_pkg::mid_t up_data,
	hsvc_out_if.source     pix_out
);

	localparam int QT_SHIFT_HI = hsvc_pkg::QT_SHIFT + 7;

	logic          vld_s5, vld_s6;
	logic          en5, en6;
	logic [22:0]   sum_q, sum_t;
	logic [19:0]   yq, yt;
	logic [41:0]   qprod, tprod;
	logic [7:0]    alpha_s5, val_s5, p_s5;
	logic [2:0]    sector_s5;
	logic [41:0]   qprod_s5, tprod_s5;
	logic [7:0]    q, t;
	logic [7:0]    red, green, blue;
	logic [31:0]   color_s6;

	assign en6 = !vld_s6 || pix_out.ready;
	assign en5 = !vld_s5 || en6;
	assign up_ready = en5;

	// floor((2n + 15300) / 30600) = floor(floor((n + 7650) / 4) / 3825)
	assign sum_q = 23'(up_data.nq) + 23'(hsvc_pkg::QT_BIAS);
	assign sum_t = 23'(up_data.nt) + 23'(hsvc_pkg::QT_BIAS);
	assign yq    = sum_q[21:2];
	assign yt    = sum_t[21:2];
	assign qprod = 42'(yq) * 42'(hsvc_pkg::QT_RECIP);
	assign tprod = 42'(yt) * 42'(hsvc_pkg::QT_RECIP);

	assign q = qprod_s5[QT_SHIFT_HI:hsvc_pkg::QT_SHIFT];
	assign t = tprod_s5[QT_SHIFT_HI:hsvc_pkg::QT_SHIFT];

	always_comb begin
		case (sector_s5)
			hsvc_pkg::SECT_RED: begin
				red = val_s5; green = t; blue = p_s5;
			end
			hsvc_pkg::SECT_YEL: begin
				red = q; green = val_s5; blue = p_s5;
			end
			hsvc_pkg::SECT_GRN: begin
				red = p_s5; green = val_s5; blue = t;
			end
			hsvc_pkg::SECT_CYN: begin
				red = p_s5; green = q; blue = val_s5;
			end
			hsvc_pkg::SECT_BLU: begin
				red = t; green = p_s5; blue = val_s5;
			end
			default: begin
				red = val_s5; green = p_s5; blue = q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en5) begin
				vld_s5 <= up_valid;
			end
			if (en6) begin
				vld_s6 <= vld_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && up_valid) begin
			alpha_s5  <= up_data.alpha;
			sector_s5 <= up_data.sector;
			val_s5    <= up_data.val;
			p_s5      <= up_data.p;
			qprod_s5  <= qprod;
			tprod_s5  <= tprod;
		end
		if (en6 && vld_s5) begin
			color_s6 <= {alpha_s5, red, green, blue};
		end
	end

	assign pix_out.valid     = vld_s6;
	assign pix_out.color_out = color_s6;

	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && !en6) |=> (vld_s5 && $stable(qprod_s5) && $stable(tprod_s5)))
		else $error("stage 5 lost its beat during a stall");

	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && vld_s6 && !pix_out.ready) |-> !up_ready)
		else $error("back stages accept while full and stalled");

endmodule

FILE: rtl/hsv_to_rgb_color_core.sv
// top level of the hsv to rgb color pipeline
// depends on hsvc_pkg, hsvc_if, hsvc_front, hsvc_mid and hsvc_back
//
// pix_in carries one beat per pixel: the packed argb color, hue in degrees,
// saturation and brightness. pix_out carries the packed argb result: input
// alpha in bits 31:24, then red, green and blue bytes.
// both channels are valid/ready; a beat moves when both are high.
// the block is a six-stage pipeline: a beat accepted from pix_in passes
// through stage registers s1 to s6 in order, and s6 drives pix_out. one beat is
// accepted every cycle while nothing stalls; each stage holds one beat
// and its own valid bit, so bubbles close up and a stall on pix_out only
// stops the stages behind full ones.
// pix_in.ready falls once all six stages hold beats and pix_out is stalled.
// hue values of 360 and above wrap into the six sectors.
// arst_n clears all valid bits; the block is empty and ready after reset.

module hsv_to_rgb_color_core (
	input  logic        clk,
	input  logic        arst_n,
	hsvc_in_if.sink     pix_in,
	hsvc_out_if.source  pix_out
);

	logic              front_valid, front_ready;
	hsvc_pkg::front_t  front_data;
	logic              mid_valid, mid_ready;
	hsvc_pkg::mid_t    mid_data;

	hsvc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix_in),
		.dn_valid (front_valid),
		.dn_ready (front_ready),
		.dn_data  (front_data)
	);

	hsvc_mid u_mid (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (front_valid),
		.up_ready (front_ready),
		.up_data  (front_data),
		.dn_valid (mid_valid),
		.dn_ready (mid_ready),
		.dn_data  (mid_data)
	);

	hsvc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (mid_valid),
		.up_ready (mid_ready),
		.up_data  (mid_data),
		.pix_out  (pix_out)
	);

endmodule
